// ===== rtl/core/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery range learner package
// Shared types, constants and state codes for the range learner.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam int RATE_FRAC_DEF  = 12;

    localparam logic [2:0] REG_INITIAL_RATE = 3'd0;
    localparam logic [2:0] REG_RATE_FLOOR   = 3'd1;
    localparam logic [2:0] REG_RATE_CEILING = 3'd2;
    localparam logic [2:0] REG_LEARN_WEIGHT = 3'd3;
    localparam logic [2:0] REG_DISCH_WEIGHT = 3'd4;

    localparam logic [31:0] MIDRIDE_MS = 32'd1800000;

    typedef struct packed {
        logic [6:0]  charge_pct;
        logic [28:0] odometer_ckm;
        logic [15:0] ride_seconds;
        logic [31:0] trip_len;
        logic [31:0] clock_ms;
    } brl_in_t;

    typedef struct packed {
        logic [15:0] learned_rate;
        logic [14:0] range_estimate;
        logic        write_request;
        logic [15:0] record_seq;
        logic [3:0]  record_slot;
        logic [6:0]  record_charge;
        logic [31:0] record_odometer_m;
    } brl_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_LDIV,
        ST_LBLEND,
        ST_DPREP,
        ST_DDIV,
        ST_DBLEND,
        ST_FINISH,
        ST_OUT
    } brl_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic ldiv_start;
        logic div_step;
        logic lblend;
        logic ddiv_start;
        logic dblend;
        logic finish;
        logic emit;
    } brl_cmd_t;

    typedef struct packed {
        logic learn_go;
        logic disch_go;
        logic div_done;
    } brl_stat_t;

endpackage

// ===== rtl/core/brl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Range learner controller
// Sequences one tick through the window test, divisions, blends and output.
// ----------------------------------------------------------------------------
module brl_ctrl
    import brl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_busy,
    input  brl_stat_t stat,
    output logic      idle,
    output brl_cmd_t  cmd
);

    brl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = ST_DPREP;
                if (stat.learn_go)
                begin
                    cmd.ldiv_start = 1'b1;
                    state_next = ST_LDIV;
                end
            end
            ST_LDIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_LBLEND;
                end
            end
            ST_LBLEND:
            begin
                cmd.lblend = 1'b1;
                state_next = ST_DPREP;
            end
            ST_DPREP:
            begin
                state_next = ST_FINISH;
                if (stat.disch_go)
                begin
                    cmd.ddiv_start = 1'b1;
                    state_next = ST_DDIV;
                end
            end
            ST_DDIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_DBLEND;
                end
            end
            ST_DBLEND:
            begin
                cmd.dblend = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    property p_div_only_in_div;
        @(posedge clk) disable iff (!rst_n)
            cmd.div_step |-> (state_reg == ST_LDIV || state_reg == ST_DDIV);
    endproperty
    a_div_only_in_div: assert property (p_div_only_in_div)
        else $error("Divider stepped outside a divide state.");

    property p_load_from_idle;
        @(posedge clk) disable iff (!rst_n)
            in_fire |-> state_reg == ST_IDLE;
    endproperty
    a_load_from_idle: assert property (p_load_from_idle)
        else $error("Word accepted while busy.");

    property p_emit_returns_idle;
        @(posedge clk) disable iff (!rst_n)
            cmd.emit |=> state_reg == ST_IDLE;
    endproperty
    a_emit_returns_idle: assert property (p_emit_returns_idle)
        else $error("Controller did not return to idle after emit.");

endmodule

// ===== rtl/core/brl_datapath.sv =====
// ----------------------------------------------------------------------------
// Range learner datapath
// Tick state, a shared restoring divider, blend and checkpoint logic.
// ----------------------------------------------------------------------------
module brl_datapath
    import brl_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int RATE_FRAC  = RATE_FRAC_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  brl_cmd_t    cmd,
    input  brl_in_t     in_word,
    input  logic        cfg_fire,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output brl_stat_t   stat,
    output brl_out_t    out_word
);

    localparam int DW   = 32 + RATE_FRAC;
    localparam int DXW  = DW + 1;
    localparam int DCW  = $clog2(DW + 1);
    localparam int SW   = $clog2(SLOT_COUNT + 1);
    localparam int SHR  = RATE_FRAC - 4;

    logic [15:0] initial_rate_reg, rate_floor_reg, rate_ceiling_reg;
    logic [15:0] learn_weight_reg, disch_weight_reg;
    logic [15:0] rate_reg;
    logic [6:0]  window_charge_reg;
    logic [31:0] window_odo_reg;
    logic [15:0] window_sec_reg;
    logic        window_valid_reg;
    logic [6:0]  prev_charge_reg;
    logic [31:0] prev_odo_reg;
    logic        pending_reg;
    logic [15:0] next_seq_reg;
    logic [SW-1:0] next_slot_reg;
    logic        midride_reg;
    logic [31:0] last_ms_reg;
    logic [6:0]  peak_reg;

    brl_in_t     in_reg;
    logic [31:0] odo_m_reg;
    logic        wr_reg;

    logic [DW-1:0]  quot_reg;
    logic [DW-1:0]  rem_reg;
    logic [39:0]    divisor_reg;
    logic [DCW-1:0] div_cnt_reg;

    logic [SW-1:0] seq_slot_reg;
    logic [15:0]   seq_reg;

    // Window evaluation against the latched tick.
    logic        odo_fall, chg_rise, wv_eff, learn_go;
    logic [31:0] odo_step;
    logic [6:0]  peak_eff, w_chg;
    logic [31:0] w_odo, span_m;
    logic [15:0] w_sec, dt;
    logic [6:0]  drop, fdrop;
    logic        pace_ok, disch_go;

    always_comb
    begin
        odo_step = odo_m_reg - prev_odo_reg;
        odo_fall = odo_step[31];
        chg_rise = (prev_charge_reg != 7'd0) && (in_reg.charge_pct > prev_charge_reg);
        wv_eff   = window_valid_reg && !odo_fall && !chg_rise;
        peak_eff = (in_reg.charge_pct > peak_reg) ? in_reg.charge_pct : peak_reg;
        w_chg    = wv_eff ? window_charge_reg : in_reg.charge_pct;
        w_odo    = wv_eff ? window_odo_reg : odo_m_reg;
        w_sec    = wv_eff ? window_sec_reg : in_reg.ride_seconds;
        drop     = (w_chg > in_reg.charge_pct) ? w_chg - in_reg.charge_pct : 7'd0;
        span_m   = (odo_m_reg >= w_odo) ? odo_m_reg - w_odo : 32'd0;
        dt       = (in_reg.ride_seconds >= w_sec) ? in_reg.ride_seconds - w_sec : 16'd0;
        pace_ok  = (dt != 16'd0) &&
                   ({10'd0, span_m} * 42'd1000 >= 42'd833 * {26'd0, dt});
        learn_go = (drop >= 7'd2) && (span_m > 32'd50) && pace_ok;
        fdrop    = (peak_reg > in_reg.charge_pct) ? peak_reg - in_reg.charge_pct : 7'd0;
        disch_go = (fdrop > 7'd80) && (in_reg.trip_len >= 32'd100);
    end

    // Divider: one quotient bit per cycle.
    logic [DW:0] rem_sh;
    logic [DW:0] div_ext;
    always_comb
    begin
        rem_sh  = {rem_reg, quot_reg[DW-1]};
        div_ext = DXW'(divisor_reg);
    end

    function automatic logic [15:0] clamp_rate(input logic [DW-1:0] v,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
        logic [DW-1:0] t;
        t = v;
        if (t < DW'(lo)) t = DW'(lo);
        if (t > DW'(hi)) t = DW'(hi);
        return t[15:0];
    endfunction

    logic [15:0] sample;
    logic [15:0] blend_w;
    logic [33:0] acc;
    logic [15:0] nw, dlt;
    logic        sig3, sig5;
    always_comb
    begin
        sample  = clamp_rate(quot_reg, rate_floor_reg, rate_ceiling_reg);
        blend_w = cmd.dblend ? disch_weight_reg : learn_weight_reg;
        acc = 34'(({1'b0, 17'h10000 - {1'b0, blend_w}}) * {17'd0, rate_reg})
            + 34'({18'd0, blend_w} * {18'd0, sample}) + 34'd32768;
        nw  = clamp_rate(DW'(acc >> 16), rate_floor_reg, rate_ceiling_reg);
        dlt = (nw > rate_reg) ? nw - rate_reg : rate_reg - nw;
        sig3 = ({7'd0, dlt} * 23'd100 >= 23'(1 << RATE_FRAC)) ||
               ({7'd0, dlt} * 23'd100 >= 23'd3 * {7'd0, rate_reg});
        sig5 = ({7'd0, dlt} * 23'd100 >= 23'(1 << RATE_FRAC)) ||
               ({7'd0, dlt} * 23'd100 >= 23'd5 * {7'd0, rate_reg});
    end

    // Checkpoint decision at the end of the tick.
    logic pend_d, wr_d, mid_d;
    logic [31:0] last_d;
    always_comb
    begin
        pend_d = pending_reg;
        wr_d   = wr_reg;
        mid_d  = midride_reg;
        last_d = last_ms_reg;
        if (in_reg.charge_pct >= 7'd99 && pend_d)
        begin
            wr_d = 1'b1;
            pend_d = 1'b0;
            last_d = in_reg.clock_ms;
        end
        if (!mid_d && pend_d && in_reg.charge_pct <= 7'd50 &&
            (in_reg.clock_ms - last_d) >= MIDRIDE_MS && in_reg.trip_len >= 32'd1000)
        begin
            wr_d = 1'b1;
            pend_d = 1'b0;
            last_d = in_reg.clock_ms;
            mid_d = 1'b1;
        end
    end

    logic [31:0] est;
    always_comb
    begin
        est = ({25'd0, in_reg.charge_pct} * {16'd0, rate_reg}) >> SHR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_rate_reg <= 16'd1229;
            rate_floor_reg   <= 16'd205;
            rate_ceiling_reg <= 16'd6144;
            learn_weight_reg <= 16'd13107;
            disch_weight_reg <= 16'd32768;
            rate_reg         <= 16'd1229;
            window_charge_reg <= '0;
            window_odo_reg   <= '0;
            window_sec_reg   <= '0;
            window_valid_reg <= 1'b0;
            prev_charge_reg  <= '0;
            prev_odo_reg     <= '0;
            pending_reg      <= 1'b0;
            next_seq_reg     <= 16'd1;
            next_slot_reg    <= SW'(1 % SLOT_COUNT);
            midride_reg      <= 1'b0;
            last_ms_reg      <= '0;
            peak_reg         <= 7'd100;
            wr_reg           <= 1'b0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_INITIAL_RATE:
                    begin
                        initial_rate_reg <= cfg_data;
                        rate_reg <= cfg_data;
                    end
                    REG_RATE_FLOOR:   rate_floor_reg <= cfg_data;
                    REG_RATE_CEILING: rate_ceiling_reg <= cfg_data;
                    REG_LEARN_WEIGHT: learn_weight_reg <= cfg_data;
                    REG_DISCH_WEIGHT: disch_weight_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                wr_reg <= 1'b0;
            end
            if (cmd.prep)
            begin
                peak_reg <= peak_eff;
                window_valid_reg  <= 1'b1;
                window_charge_reg <= learn_go ? in_reg.charge_pct : w_chg;
                window_odo_reg    <= learn_go ? odo_m_reg : w_odo;
                window_sec_reg    <= learn_go ? in_reg.ride_seconds : w_sec;
            end
            if (cmd.ldiv_start || cmd.ddiv_start)
            begin
                div_cnt_reg <= DCW'(DW);
            end
            else if (cmd.div_step && div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end
            if (cmd.lblend)
            begin
                rate_reg <= nw;
                if (sig3) pending_reg <= 1'b1;
            end
            if (cmd.dblend)
            begin
                rate_reg <= nw;
                window_valid_reg <= 1'b0;
                if (sig5 || pending_reg)
                begin
                    wr_reg <= 1'b1;
                    pending_reg <= 1'b0;
                    last_ms_reg <= in_reg.clock_ms;
                end
            end
            if (cmd.finish)
            begin
                pending_reg <= pend_d;
                wr_reg      <= wr_d;
                midride_reg <= mid_d;
                last_ms_reg <= last_d;
                if (in_reg.charge_pct >= 7'd99)
                begin
                    peak_reg <= in_reg.charge_pct;
                    window_valid_reg <= 1'b0;
                end
            end
            if (cmd.emit)
            begin
                prev_charge_reg <= in_reg.charge_pct;
                prev_odo_reg    <= odo_m_reg;
                if (wr_reg)
                begin
                    next_seq_reg <= next_seq_reg + 16'd1;
                    if (next_seq_reg == 16'hFFFF ||
                        next_slot_reg == SW'(SLOT_COUNT - 1))
                    begin
                        next_slot_reg <= '0;
                    end
                    else
                    begin
                        next_slot_reg <= next_slot_reg + SW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg    <= in_word;
            odo_m_reg <= 32'({3'd0, in_word.odometer_ckm} * 32'd10);
        end
        if (cmd.ldiv_start)
        begin
            quot_reg    <= DW'({span_m, {RATE_FRAC{1'b0}}});
            rem_reg     <= '0;
            divisor_reg <= 40'({33'd0, drop} * 40'd1000);
        end
        else if (cmd.ddiv_start)
        begin
            quot_reg    <= DW'({in_reg.trip_len, {RATE_FRAC{1'b0}}});
            rem_reg     <= '0;
            divisor_reg <= 40'({33'd0, fdrop} * 40'd100);
        end
        else if (cmd.div_step && div_cnt_reg != '0)
        begin
            if (rem_sh >= div_ext)
            begin
                rem_reg  <= DW'(rem_sh - div_ext);
                quot_reg <= {quot_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[DW-1:0];
                quot_reg <= {quot_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            seq_reg      <= next_seq_reg;
            seq_slot_reg <= next_slot_reg;
        end
    end

    always_comb
    begin
        stat.learn_go = learn_go;
        stat.disch_go = disch_go;
        stat.div_done = (div_cnt_reg == DCW'(1));
        out_word.learned_rate   = rate_reg;
        out_word.range_estimate = (est > 32'd32767) ? 15'h7fff : est[14:0];
        out_word.write_request  = wr_reg;
        out_word.record_seq     = wr_reg ? seq_reg : 16'd0;
        out_word.record_slot    = wr_reg ? 4'(seq_slot_reg) : 4'd0;
        out_word.record_charge  = wr_reg ? in_reg.charge_pct : 7'd0;
        out_word.record_odometer_m = wr_reg ? prev_odo_reg : 32'd0;
    end

    property p_rate_in_range;
        @(posedge clk) disable iff (!rst_n)
            $past(cmd.lblend) && (rate_floor_reg <= rate_ceiling_reg) |->
                rate_reg <= rate_ceiling_reg;
    endproperty
    a_rate_in_range: assert property (p_rate_in_range)
        else $error("Learned rate above ceiling after blend.");

    property p_seq_advance;
        @(posedge clk) disable iff (!rst_n)
            cmd.emit && wr_reg |=> next_seq_reg == $past(next_seq_reg) + 16'd1;
    endproperty
    a_seq_advance: assert property (p_seq_advance)
        else $error("Sequence did not advance after a checkpoint.");

    property p_slot_bound;
        @(posedge clk) disable iff (!rst_n)
            cmd.emit && wr_reg |-> seq_slot_reg < SW'(SLOT_COUNT);
    endproperty
    a_slot_bound: assert property (p_slot_bound)
        else $error("Record slot out of range.");

endmodule

// ===== rtl/core/battery_range_learner_unit.sv =====
// ----------------------------------------------------------------------------
// Battery range learner unit
// Learns km per percent of charge and estimates remaining range.
// ----------------------------------------------------------------------------
// One input word per tick on in_valid/in_ready; one result word per tick on
// out_valid/out_ready. Configuration writes use cfg_valid/cfg_ready with a
// register index and 16-bit data, and are taken only while the unit is idle.
// A taken word passes through the window test, an optional learn division and
// blend, an optional discharge division and blend, the checkpoint step and the
// output step, which registers the result. Both rate divisions use a shared
// restoring divider at one quotient bit per cycle.
// The unit works on one word at a time; the next word can be taken in the
// cycle after the result has been moved into the output register.
// Reset restores the register defaults, sets the learned rate to the initial
// rate and clears the window and checkpoint state.
// When the receiver stalls, the result holds in the output register and the
// unit accepts one more word, then waits before showing its result.
// ----------------------------------------------------------------------------
module battery_range_learner_unit
    import brl_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int RATE_FRAC  = RATE_FRAC_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  brl_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output brl_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    brl_cmd_t  cmd;
    brl_stat_t stat;
    brl_out_t  result;
    brl_out_t  out_reg;
    logic      out_valid_reg;
    logic      idle;

    assign in_ready  = idle;
    assign cfg_ready = idle;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    brl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && idle),
        .out_busy (out_valid_reg && !out_ready),
        .stat     (stat),
        .idle     (idle),
        .cmd      (cmd)
    );

    brl_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .RATE_FRAC  (RATE_FRAC)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   (in_data),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .out_word  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= result;
        end
    end

endmodule

// ===== bench/battery_range_learner_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range learner checker
// Watches the input, result and register write channels of the range learner,
// predicts every result word from its own model of the learner and compares
// the two field by field.
// ----------------------------------------------------------------------------
module battery_range_learner_unit_checker
    import brl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  brl_in_t     in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  brl_out_t    out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          error_count,
    output int          waiting_count
);

    localparam int FRAC = RATE_FRAC_DEF;

    logic [15:0] initial_rate, rate_floor, rate_ceiling, learn_weight, disch_weight;
    logic [15:0] rate;
    logic [6:0]  win_charge, prev_charge, peak_charge;
    logic [31:0] win_odo_m, prev_odo_m, last_write_ms;
    logic [15:0] win_secs, next_seq;
    logic        win_valid, pending, midride_done;

    brl_out_t expected_results[$];

    assign waiting_count = expected_results.size();

    function automatic logic [63:0] limit_rate(logic [63:0] v);
        logic [63:0] r;
        r = v;
        if (r < rate_floor)
            r = rate_floor;
        if (r > rate_ceiling)
            r = rate_ceiling;
        return r;
    endfunction

    function automatic logic mix_rate(logic [63:0] sample, logic [15:0] w, int k);
        logic [63:0] acc;
        logic [15:0] old, nw;
        logic [63:0] d;
        old = rate;
        acc = (64'd65536 - w) * old + 64'(w) * sample + 64'd32768;
        nw = 16'(limit_rate(acc >> 16));
        d = (nw > old) ? nw - old : old - nw;
        rate = nw;
        return (d * 100 >= (64'd1 << FRAC)) || (d * 100 >= 64'(k) * old);
    endfunction

    task automatic predict_result(brl_in_t t);
        logic [31:0] soc, odo, secs, trip, now, drop, span_m, dt, fdrop;
        logic [63:0] s, est;
        logic        wr, pace_ok;
        logic [15:0] seq;
        brl_out_t    r;
        soc = t.charge_pct;
        odo = 32'(t.odometer_ckm) * 10;
        secs = t.ride_seconds;
        trip = t.trip_len;
        now = t.clock_ms;
        wr = 0;
        seq = 0;
        if (((odo - prev_odo_m) & 32'h8000_0000) != 0)
            win_valid = 0;
        if (soc > peak_charge)
            peak_charge = 7'(soc);
        if (prev_charge != 0 && soc > prev_charge)
            win_valid = 0;
        if (!win_valid)
        begin
            win_charge = 7'(soc); win_odo_m = odo; win_secs = 16'(secs); win_valid = 1;
        end
        drop = (win_charge > soc) ? win_charge - soc : 0;
        span_m = (odo >= win_odo_m) ? odo - win_odo_m : 0;
        dt = (secs >= win_secs) ? secs - win_secs : 0;
        pace_ok = dt > 0 && 64'(span_m) * 1000 >= 64'd833 * dt;
        if (drop >= 2 && span_m > 50 && pace_ok)
        begin
            s = limit_rate((64'(span_m) << FRAC) / (64'd1000 * drop));
            if (mix_rate(s, learn_weight, 3))
                pending = 1;
            win_charge = 7'(soc); win_odo_m = odo; win_secs = 16'(secs); win_valid = 1;
        end
        fdrop = (peak_charge > soc) ? peak_charge - soc : 0;
        if (fdrop > 80 && trip >= 100)
        begin
            s = limit_rate((64'(trip) << FRAC) / (64'd100 * fdrop));
            if (mix_rate(s, disch_weight, 5))
                pending = 1;
            win_valid = 0;
            if (pending)
            begin
                wr = 1; pending = 0; last_write_ms = now;
            end
        end
        if (soc >= 99)
        begin
            if (pending)
            begin
                wr = 1; pending = 0; last_write_ms = now;
            end
            peak_charge = 7'(soc);
            win_valid = 0;
        end
        if (!midride_done && pending && soc <= 50 && (now - last_write_ms) >= MIDRIDE_MS
            && trip >= 1000)
        begin
            wr = 1; pending = 0; last_write_ms = now; midride_done = 1;
        end
        if (wr)
        begin
            seq = next_seq;
            next_seq = next_seq + 16'd1;
        end
        est = (64'(soc) * rate) >> (FRAC - 4);
        if (est > 32767)
            est = 32767;
        r.learned_rate = rate;
        r.range_estimate = 15'(est);
        r.write_request = wr;
        r.record_seq = wr ? seq : 16'd0;
        r.record_slot = wr ? 4'(seq % SLOT_COUNT_DEF) : 4'd0;
        r.record_charge = wr ? 7'(soc) : 7'd0;
        r.record_odometer_m = wr ? prev_odo_m : 32'd0;
        expected_results.push_back(r);
        prev_charge = 7'(soc);
        prev_odo_m = odo;
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    initial
    begin
        error_count = 0;
        initial_rate = 1229; rate_floor = 205; rate_ceiling = 6144;
        learn_weight = 13107; disch_weight = 32768;
        rate = 1229;
        win_charge = 0; win_odo_m = 0; win_secs = 0; win_valid = 0;
        prev_charge = 0; prev_odo_m = 0; pending = 0; next_seq = 1;
        midride_done = 0; last_write_ms = 0; peak_charge = 100;
    end

    always @(posedge clk)
    begin
        brl_out_t e;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INITIAL_RATE: begin initial_rate = cfg_data; rate = cfg_data; end
                    REG_RATE_FLOOR:   rate_floor = cfg_data;
                    REG_RATE_CEILING: rate_ceiling = cfg_data;
                    REG_LEARN_WEIGHT: learn_weight = cfg_data;
                    REG_DISCH_WEIGHT: disch_weight = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report("result count", 64'd1, 64'd0);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_data.learned_rate !== e.learned_rate)
                        report("learned_rate", out_data.learned_rate, e.learned_rate);
                    if (out_data.range_estimate !== e.range_estimate)
                        report("range_estimate", out_data.range_estimate, e.range_estimate);
                    if (out_data.write_request !== e.write_request)
                        report("write_request", out_data.write_request, e.write_request);
                    if (out_data.record_seq !== e.record_seq)
                        report("record_seq", out_data.record_seq, e.record_seq);
                    if (out_data.record_slot !== e.record_slot)
                        report("record_slot", out_data.record_slot, e.record_slot);
                    if (out_data.record_charge !== e.record_charge)
                        report("record_charge", out_data.record_charge, e.record_charge);
                    if (out_data.record_odometer_m !== e.record_odometer_m)
                        report("record_odometer_m", out_data.record_odometer_m,
                               e.record_odometer_m);
                end
            end
            if (in_valid && in_ready)
                predict_result(in_data);
        end
    end

endmodule

// ===== bench/battery_range_learner_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range learner testbench
// Drives directed and random ride profiles and register settings into the
// range learner with random gaps and stalls, except in a final calm run; a
// checker beside the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module battery_range_learner_unit_test;
    import brl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
    brl_in_t     in_data;
    brl_out_t    out_data;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          error_count, waiting_count;
    logic        calm;
    int          stall_left;

    logic [6:0]  ride_charge;
    logic [28:0] ride_odo;
    logic [15:0] ride_secs;
    logic [31:0] ride_trip, ride_clock;

    battery_range_learner_unit uut (.*);
    battery_range_learner_unit_checker checker_i (.*);

    initial clk = 0;
    always #1 clk = ~clk;

    initial
    begin
        #4000000;
        $display("[battery_range_learner_unit] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            out_ready <= 1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 0;
            stall_left--;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            out_ready <= 0;
            stall_left = $urandom_range(0, 9);
        end
        else
            out_ready <= 1;
    end

    task automatic send_word(brl_in_t w);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_tick(logic [6:0] c, logic [28:0] o, logic [15:0] s,
                             logic [31:0] t, logic [31:0] m);
        brl_in_t w;
        w.charge_pct = c; w.odometer_ckm = o; w.ride_seconds = s;
        w.trip_len = t; w.clock_ms = m;
        send_word(w);
    endtask

    task automatic drain();
        int i;
        in_valid <= 0;
        while (waiting_count != 0)
            @(posedge clk);
        for (i = 0; i < 150; i++)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_setting(logic [15:0] r0, logic [15:0] r1, logic [15:0] r2,
                                 logic [15:0] r3, logic [15:0] r4);
        drain();
        write_reg(REG_INITIAL_RATE, r0);
        write_reg(REG_RATE_FLOOR, r1);
        write_reg(REG_RATE_CEILING, r2);
        write_reg(REG_LEARN_WEIGHT, r3);
        write_reg(REG_DISCH_WEIGHT, r4);
        cfg_valid <= 0;
    endtask

    // Mostly a plausible ride (charge falls slowly, odometer and time advance); else one field jumps.
    task automatic ride_tick();
        int step;
        if ($urandom_range(0, 99) < 85)
        begin
            step = $urandom_range(0, 3);
            ride_charge = (ride_charge > step) ? ride_charge - 7'(step) : 7'd0;
            ride_odo += 29'($urandom_range(0, 200));
            ride_secs += 16'($urandom_range(0, 60));
            ride_trip += $urandom_range(0, 200);
            ride_clock += $urandom_range(0, 400000);
        end
        else
            case ($urandom_range(0, 4))
                0: ride_charge = 7'($urandom_range(0, 127));
                1: ride_odo = 29'($urandom);
                2: ride_charge = 7'($urandom_range(95, 100));
                3: ride_clock = $urandom;
                default: ride_trip = $urandom;
            endcase
        send_tick(ride_charge, ride_odo, ride_secs, ride_trip, ride_clock);
    endtask

    task automatic random_ride(int n);
        int i;
        ride_charge = 7'($urandom_range(90, 100));
        ride_odo = 29'($urandom_range(0, 1000000));
        ride_secs = 16'($urandom_range(0, 60000));
        ride_trip = $urandom_range(0, 2000);
        ride_clock = $urandom;
        for (i = 0; i < n; i++)
            ride_tick();
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = REG_INITIAL_RATE;
        cfg_data = 0;
        calm = 0;
        out_ready = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_tick(100, 1000, 100, 0, 0);
        send_tick(97, 1100, 200, 100, 1000);
        send_tick(95, 1200, 260, 200, 2000);
        send_tick(96, 1300, 300, 300, 3000);
        send_tick(93, 800, 400, 400, 4000);
        send_tick(90, 1000, 500, 500, 5000);
        send_tick(15, 5000, 6000, 50000, 2000000);
        send_tick(10, 6000, 7000, 60000, 4000000);
        send_tick(5, 7000, 8000, 99, 6000000);
        send_tick(0, 29'h1FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(127, 0, 0, 0, 0);
        send_tick(99, 100, 10, 0, 32'hFFFF_FFF0);
        send_tick(50, 100000, 1000, 5000, 10);
        send_tick(48, 101000, 1100, 6000, 1900000);
        send_tick(45, 102000, 1200, 7000, 3800000);
        send_tick(7'h55, 29'h0AAA_AAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_tick(7'h2A, 29'h1555_5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        write_setting(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_ride(120);
        write_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_ride(60);
        write_setting(16'd2000, 16'd5000, 16'd1000, 16'd30000, 16'd100);
        random_ride(60);
        write_setting(16'($urandom), 16'($urandom_range(0, 500)),
                      16'($urandom_range(3000, 65535)), 16'($urandom), 16'($urandom));
        random_ride(150);
        drain();
        write_setting(1229, 205, 6144, 13107, 32768);
        random_ride(150);
        calm = 1;
        random_ride(100);

        drain();
        if (error_count == 0)
            $display("[battery_range_learner_unit] OK");
        else
            $display("[battery_range_learner_unit] ERROR");
        $finish;
    end

endmodule
